// ===== sv/glzw_pkg.sv =====
package glzw_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int TABLE_DEPTH_DEF   = 4096;
  localparam int ACC_W             = 20;
  localparam int HELD_W            = 5;
  localparam int FEED_LIMIT        = 12;
  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_NEED   = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_ACCEPT = 3'd3;
  localparam logic [2:0] ST_REFUSE = 3'd4;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef logic [2:0] status_t;

  // clamp the minimum code size to 2..9 and below the widest code
  function automatic logic [3:0] eff_size(input logic [3:0] m, input int max_bits);
    logic [3:0] r;
    r = m;
    if (r < 4'd2) r = 4'd2;
    if (r > 4'd9) r = 4'd9;
    if (r > 4'(max_bits - 1)) r = 4'(max_bits - 1);
    return r;
  endfunction

endpackage

// ===== sv/glzw_ram.sv =====
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gif_lzw_decoder.sv =====
// GIF LZW decoder, one transaction at a time under a small sequencer.
// Feed: the update is registered into the result, then into the output register.
// Pull with pixels on the stack: S_POP, S_POPW (stack read is registered), S_EMIT.
// Pull that decodes a code: S_DEC, then S_WALK/S_WALK2 with one table read per node;
// the first code after a clear goes from S_DEC to S_EMIT; each clear code adds a pass through S_DEC.
// A new transaction is taken only once the last result is in the output register; an output stall holds it.
// Reset (rst_n low, synchronous) and each config write restart the decoder.
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int TABLE_DEPTH   = glzw_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel,
  output logic [2:0]  out_status
);

  localparam int MB  = MAX_CODE_BITS;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SPW = AW + 1;
  localparam int NSW = MB + 1;
  localparam logic [SPW-1:0] SP_TOP  = SPW'(TABLE_DEPTH - 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_WALK2 = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_POPW  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [3:0]        min_r, min_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [NSW-1:0]    slot_r, slot_nxt;
  logic [NSW-1:0]    limit_r, limit_nxt;
  logic [MB-1:0]     old_r, old_nxt;
  logic [7:0]        fc_r, fc_nxt;
  logic              aclr_r, aclr_nxt;
  logic              ended_r, ended_nxt;
  logic              done_r, done_nxt;
  logic [MB-1:0]     w_r, w_nxt;
  logic [MB-1:0]     c_r, c_nxt;
  logic [7:0]        res_pix_r, res_pix_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_pix_r, out_pix_nxt;
  status_t           out_st_r, out_st_nxt;

  logic [3:0]        eff, cfg_eff;
  logic [MB-1:0]     clear_code, newcodes;
  logic [ACC_W-1:0]  mask;
  logic [MB-1:0]     code;
  logic [NSW-1:0]    slot_new;
  logic              cfg_acc, in_acc;

  logic              stk_we;
  logic [7:0]        stk_wdata, stk_q;
  logic [AW-1:0]     stk_raddr;
  logic              tab_we;
  logic [MB-1:0]     pre_q;
  logic [7:0]        suf_q;

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp_r[AW-1:0]), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
    .clk(clk), .we(tab_we), .waddr(slot_r[AW-1:0]), .wdata(w_r[7:0]),
    .raddr(w_r[AW-1:0]), .rdata(suf_q)
  );

  glzw_ram #(.WIDTH(MB), .DEPTH(TABLE_DEPTH)) u_prefix (
    .clk(clk), .we(tab_we), .waddr(slot_r[AW-1:0]), .wdata(old_r),
    .raddr(w_r[AW-1:0]), .rdata(pre_q)
  );

  assign eff        = eff_size(min_r, MB);
  assign cfg_eff    = eff_size(cfg_data, MB);
  assign clear_code = MB'(1) << eff;
  assign newcodes   = clear_code + MB'(2);
  assign mask       = (ACC_W'(1) << cw_r) - ACC_W'(1);
  assign code       = MB'(acc_r & mask);
  assign slot_new   = slot_r + NSW'(1);
  assign stk_raddr  = AW'(sp_r - SPW'(1));

  assign cfg_ready  = (state_r == S_IDLE);
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign in_ready   = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pix_r;
  assign out_status = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    sp_nxt        = sp_r;
    acc_nxt       = acc_r;
    held_nxt      = held_r;
    rem_nxt       = rem_r;
    cw_nxt        = cw_r;
    slot_nxt      = slot_r;
    limit_nxt     = limit_r;
    old_nxt       = old_r;
    fc_nxt        = fc_r;
    aclr_nxt      = aclr_r;
    ended_nxt     = ended_r;
    done_nxt      = done_r;
    w_nxt         = w_r;
    c_nxt         = c_r;
    res_pix_nxt   = res_pix_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_st_nxt    = out_st_r;
    stk_we        = 1'b0;
    stk_wdata     = fc_r;
    tab_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          min_nxt   = cfg_data;
          sp_nxt    = '0;
          acc_nxt   = '0;
          held_nxt  = '0;
          rem_nxt   = '0;
          cw_nxt    = cfg_eff + 4'd1;
          slot_nxt  = (NSW'(1) << cfg_eff) + NSW'(2);
          limit_nxt = NSW'(1) << (cfg_eff + 4'd1);
          old_nxt   = '0;
          fc_nxt    = '0;
          aclr_nxt  = 1'b1;
          ended_nxt = 1'b0;
          done_nxt  = 1'b0;
        end else if (in_acc) begin
          res_pix_nxt = '0;
          if (in_opcode == OP_FEED) begin
            state_nxt = S_EMIT;
            priority if (ended_r) begin
              res_st_nxt = ST_END;
            end else if (done_r) begin
              res_st_nxt = ST_REFUSE;
            end else if (rem_r == 8'd0) begin
              if (in_data_byte == 8'd0) done_nxt = 1'b1;
              else rem_nxt = in_data_byte;
              res_st_nxt = ST_ACCEPT;
            end else if (held_r >= HELD_W'(FEED_LIMIT)) begin
              res_st_nxt = ST_REFUSE;
            end else begin
              acc_nxt    = acc_r | (ACC_W'(in_data_byte) << held_r);
              held_nxt   = held_r + HELD_W'(8);
              rem_nxt    = rem_r - 8'd1;
              res_st_nxt = ST_ACCEPT;
            end
          end else begin
            state_nxt = (sp_r != '0) ? S_POP : S_DEC;
          end
        end
      end

      S_DEC: begin
        priority if (ended_r) begin
          res_st_nxt = ST_END;
          state_nxt  = S_EMIT;
        end else if (held_r < HELD_W'(cw_r)) begin
          if (done_r) begin
            ended_nxt  = 1'b1;
            res_st_nxt = ST_END;
          end else begin
            res_st_nxt = ST_NEED;
          end
          state_nxt = S_EMIT;
        end else begin
          acc_nxt  = acc_r >> cw_r;
          held_nxt = held_r - HELD_W'(cw_r);
          priority if (code == clear_code + MB'(1)) begin
            ended_nxt  = 1'b1;
            res_st_nxt = ST_END;
            state_nxt  = S_EMIT;
          end else if (code == clear_code) begin
            cw_nxt    = eff + 4'd1;
            slot_nxt  = {1'b0, newcodes};
            limit_nxt = NSW'(1) << (eff + 4'd1);
            aclr_nxt  = 1'b1;
          end else if (aclr_r) begin
            // bad first code after clear decodes as zero
            if (NSW'(code) >= slot_r) begin
              old_nxt     = '0;
              fc_nxt      = '0;
              res_pix_nxt = '0;
            end else begin
              old_nxt     = code;
              fc_nxt      = code[7:0];
              res_pix_nxt = code[7:0];
            end
            aclr_nxt   = 1'b0;
            res_st_nxt = ST_PIXEL;
            state_nxt  = S_EMIT;
          end else begin
            c_nxt = (NSW'(code) > slot_r) ? MB'(slot_r) : code;
            if (NSW'(code) >= slot_r) begin
              w_nxt     = old_r;
              stk_we    = 1'b1;
              stk_wdata = fc_r;
              sp_nxt    = sp_r + SPW'(1);
            end else begin
              w_nxt = code;
            end
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (w_r >= newcodes && sp_r < SP_TOP) begin
          state_nxt = S_WALK2;
        end else begin
          if (sp_r < SP_FULL) begin
            stk_we    = 1'b1;
            stk_wdata = w_r[7:0];
            sp_nxt    = sp_r + SPW'(1);
          end
          if (slot_r < limit_r) begin
            tab_we   = 1'b1;
            fc_nxt   = w_r[7:0];
            slot_nxt = slot_new;
            old_nxt  = c_r;
            if (slot_new >= limit_r && cw_r < 4'(MB)) begin
              limit_nxt = limit_r << 1;
              cw_nxt    = cw_r + 4'd1;
            end
          end else if (cw_r < 4'(MB)) begin
            limit_nxt = limit_r << 1;
            cw_nxt    = cw_r + 4'd1;
          end
          state_nxt = S_POP;
        end
      end

      S_WALK2: begin
        stk_we    = 1'b1;
        stk_wdata = suf_q;
        sp_nxt    = sp_r + SPW'(1);
        w_nxt     = pre_q;
        state_nxt = S_WALK;
      end

      S_POP: begin
        sp_nxt    = sp_r - SPW'(1);
        state_nxt = S_POPW;
      end

      S_POPW: begin
        res_pix_nxt = stk_q;
        res_st_nxt  = ST_PIXEL;
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = (res_st_r == ST_PIXEL) ? res_pix_r : 8'd0;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= MIN_SIZE_RESET;
      sp_r        <= '0;
      acc_r       <= '0;
      held_r      <= '0;
      rem_r       <= '0;
      cw_r        <= eff_size(MIN_SIZE_RESET, MB) + 4'd1;
      slot_r      <= (NSW'(1) << eff_size(MIN_SIZE_RESET, MB)) + NSW'(2);
      limit_r     <= NSW'(1) << (eff_size(MIN_SIZE_RESET, MB) + 4'd1);
      old_r       <= '0;
      fc_r        <= '0;
      aclr_r      <= 1'b1;
      ended_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      held_r      <= held_nxt;
      rem_r       <= rem_nxt;
      cw_r        <= cw_nxt;
      slot_r      <= slot_nxt;
      limit_r     <= limit_nxt;
      old_r       <= old_nxt;
      fc_r        <= fc_nxt;
      aclr_r      <= aclr_nxt;
      ended_r     <= ended_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r       <= w_nxt;
    c_r       <= c_nxt;
    res_pix_r <= res_pix_nxt;
    res_st_r  <= res_st_nxt;
    out_pix_r <= out_pix_nxt;
    out_st_r  <= out_st_nxt;
  end

  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_PIXEL |-> out_pix_r == 8'd0)
    else $error("pixel not zero on non-pixel status");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_FULL)
    else $error("stack pointer overrun");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> sp_r != '0)
    else $error("pop from empty stack");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    cw_r <= 4'(MB) && held_r < HELD_W'(FEED_LIMIT + 8))
    else $error("code width or bit count out of range");

endmodule

// ===== tb/sv/tb_gif_lzw_decoder.sv =====
module tb_gif_lzw_decoder;
  import glzw_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int WIDEST = MAX_CODE_BITS_DEF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [7:0] pixel;
    status_t    status;
  } pixel_result_t;

  typedef int code_q_t[$];

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       in_opcode;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_pixel;
  logic [2:0] out_status;

  gif_lzw_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_data_byte(in_data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .out_status  (out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  longint cycles = 0;
  int     errors = 0;
  int     item_cnt;
  bit     no_idle;
  pixel_result_t pending_results[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // decoder shadow state
  int         size_reg;
  logic [11:0] prefix_mem [DEPTH];
  logic [7:0]  suffix_mem [DEPTH];
  logic [7:0]  rev_stack  [DEPTH];
  int sp, acc, held, blk_left, cw, nslot, slim, old_c, first_ch;
  bit after_clr, img_end, term_seen;

  function automatic int clamp_size(input int raw);
    int m;
    m = raw & 15;
    if (m < 2) m = 2;
    if (m > 9) m = 9;
    if (m > WIDEST - 1) m = WIDEST - 1;
    return m;
  endfunction

  function automatic void restart_codes();
    int m;
    m = clamp_size(size_reg);
    cw = m + 1;
    nslot = (1 << m) + 2;
    slim = 1 << cw;
  endfunction

  function automatic void restart_decoder();
    sp = 0;
    acc = 0;
    held = 0;
    blk_left = 0;
    restart_codes();
    old_c = 0;
    first_ch = 0;
    after_clr = 1;
    img_end = 0;
    term_seen = 0;
  endfunction

  function automatic void push_pixel(input int v);
    if (sp < DEPTH) begin
      rev_stack[sp] = 8'(v);
      sp++;
    end
  endfunction

  function automatic pixel_result_t decode_item(input logic op, input logic [7:0] b);
    pixel_result_t r;
    int clr, newcodes, code, c, w;
    r.pixel = 8'd0;
    r.status = ST_ACCEPT;
    if (op == OP_FEED) begin
      if (img_end) r.status = ST_END;
      else if (term_seen) r.status = ST_REFUSE;
      else if (blk_left == 0) begin
        if (b == 8'd0) term_seen = 1;
        else blk_left = b;
      end else if (held >= FEED_LIMIT) r.status = ST_REFUSE;
      else begin
        acc = (acc | (int'(b) << held)) & 32'hFFFFF;
        held += 8;
        blk_left--;
      end
      return r;
    end
    clr = 1 << clamp_size(size_reg);
    newcodes = clr + 2;
    while (sp == 0) begin
      if (img_end) begin
        r.status = ST_END;
        return r;
      end
      if (held < cw) begin
        if (term_seen) begin
          img_end = 1;
          r.status = ST_END;
        end else r.status = ST_NEED;
        return r;
      end
      code = acc & ((1 << cw) - 1);
      acc = acc >> cw;
      held -= cw;
      if (code == clr + 1) begin
        img_end = 1;
        r.status = ST_END;
        return r;
      end
      if (code == clr) begin
        restart_codes();
        after_clr = 1;
        continue;
      end
      if (after_clr) begin
        // bad first code after clear decodes as 0
        if (code >= nslot) code = 0;
        old_c = code;
        first_ch = code & 255;
        after_clr = 0;
        r.pixel = 8'(code);
        r.status = ST_PIXEL;
        return r;
      end
      c = code;
      if (c > nslot) c = nslot;
      w = c;
      if (w >= nslot) begin
        w = old_c;
        push_pixel(first_ch);
      end
      while (w >= newcodes && sp < DEPTH - 1) begin
        push_pixel(suffix_mem[w & (DEPTH - 1)]);
        w = prefix_mem[w & (DEPTH - 1)];
      end
      push_pixel(w);
      if (nslot < slim) begin
        first_ch = w & 255;
        suffix_mem[nslot & (DEPTH - 1)] = 8'(first_ch);
        prefix_mem[nslot & (DEPTH - 1)] = 12'(old_c);
        nslot++;
        old_c = c;
      end
      if (nslot >= slim && cw < WIDEST) begin
        slim = slim << 1;
        cw++;
      end
    end
    sp--;
    r.pixel = rev_stack[sp];
    r.status = ST_PIXEL;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, output status_t st);
    int gap;
    pixel_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    r = decode_item(op, b);
    pending_results.push_back(r);
    st = r.status;
    item_cnt++;
  endtask

  task automatic write_size(input logic [3:0] v);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    restart_decoder();
  endtask

  // random code sequence that tracks the decoder's slot count and width
  function automatic code_q_t make_codes(input int m, input int n, input int root_pct,
                                         input int clr_pct);
    code_q_t q;
    int clr, nxt, w, r, code, hi;
    bit first;
    clr = 1 << m;
    q.push_back(clr);
    nxt = clr + 2;
    w = m + 1;
    first = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (!first && r < clr_pct) begin
        q.push_back(clr);
        nxt = clr + 2;
        w = m + 1;
        first = 1;
        continue;
      end
      if (first) begin
        if (r < 10) code = $urandom_range(nxt, (1 << w) - 1);
        else code = $urandom_range(0, clr - 1);
        first = 0;
        q.push_back(code);
        continue;
      end
      hi = (nxt < (1 << w)) ? nxt : (1 << w) - 1;
      if (r < root_pct) code = $urandom_range(0, clr - 1);
      else if (r < root_pct + 3 && nxt + 1 < (1 << w))
        code = $urandom_range(nxt + 1, (1 << w) - 1);
      else code = $urandom_range(clr + 2, hi);
      q.push_back(code);
      if (nxt < (1 << w)) nxt++;
      if (nxt >= (1 << w) && w < WIDEST) w++;
    end
    if ($urandom_range(0, 3) != 0) q.push_back(clr + 1);
    return q;
  endfunction

  // pack codes LSB first, cut into sub-blocks, feed with pulls mixed in, then drain
  task automatic play_stream(input code_q_t codes, input int pull_pct);
    logic [7:0] payload[$];
    logic [7:0] raw[$];
    longint bitbuf;
    int nbits, m, clr, w, nxt, len, idx;
    bit first;
    status_t st;
    m = clamp_size(size_reg);
    clr = 1 << m;
    w = m + 1;
    nxt = clr + 2;
    first = 1;
    bitbuf = 0;
    nbits = 0;
    foreach (codes[i]) begin
      bitbuf = bitbuf | (longint'(codes[i] & ((1 << w) - 1)) << nbits);
      nbits += w;
      while (nbits >= 8) begin
        payload.push_back(bitbuf[7:0]);
        bitbuf = bitbuf >> 8;
        nbits -= 8;
      end
      if (codes[i] == clr) begin
        w = m + 1;
        nxt = clr + 2;
        first = 1;
      end else if (codes[i] != clr + 1) begin
        if (first) first = 0;
        else begin
          if (nxt < (1 << w)) nxt++;
          if (nxt >= (1 << w) && w < WIDEST) w++;
        end
      end
    end
    if (nbits > 0)
      payload.push_back(8'(bitbuf) | (8'($urandom) & ~8'((1 << nbits) - 1)));
    idx = 0;
    while (idx < payload.size()) begin
      len = payload.size() - idx;
      if ($urandom_range(0, 9) != 0 && len > 20) len = $urandom_range(1, 20);
      else if (len > 255) len = 255;
      raw.push_back(8'(len));
      repeat (len) begin
        raw.push_back(payload[idx]);
        idx++;
      end
    end
    raw.push_back(8'd0);
    idx = 0;
    while (idx < raw.size()) begin
      if ($urandom_range(0, 99) < pull_pct) send_item(OP_PULL, 8'($urandom), st);
      else begin
        send_item(OP_FEED, raw[idx], st);
        // refused bytes are not consumed; offer again
        if (st != ST_REFUSE) idx++;
      end
    end
    do send_item(OP_PULL, 8'($urandom), st); while (st != ST_END);
    send_item(OP_FEED, 8'($urandom), st);
    send_item(OP_PULL, 8'($urandom), st);
  endtask

  // result checker with its own random stalls
  initial begin
    int stall;
    pixel_result_t e;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: pixel %0d status %0d", out_pixel, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_pixel !== e.pixel) begin
          $error("pixel: expected %0d actual %0d", e.pixel, out_pixel);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_size();
    play_stream(make_codes(clamp_size(size_reg), 40, 30, 2), 40);
  endtask

  task automatic test_special_codes();
    // bad first code, code equal to next slot, code beyond it, clear, end
    write_size(4'd2);
    play_stream('{4, 7, 1, 7, 15, 2, 4, 0, 5}, 40);
  endtask

  task automatic test_wide_roots();
    write_size(4'd9);
    play_stream('{512, 300, 511, 255, 514, 513}, 40);
  endtask

  task automatic test_refuse_and_terminator();
    status_t st;
    write_size(4'd3);
    send_item(OP_PULL, 8'hFF, st);
    send_item(OP_FEED, 8'd4, st);
    send_item(OP_FEED, 8'h00, st);
    send_item(OP_FEED, 8'hFF, st);
    send_item(OP_FEED, 8'h5A, st);
    send_item(OP_PULL, 8'h00, st);
    send_item(OP_PULL, 8'h00, st);
    send_item(OP_FEED, 8'hA5, st);
    send_item(OP_FEED, 8'h3C, st);
    send_item(OP_FEED, 8'd0, st);
    // drain the held bits, then finish the sub-block and terminate
    do send_item(OP_PULL, 8'h00, st); while (st != ST_NEED && st != ST_END);
    send_item(OP_FEED, 8'h3C, st);
    send_item(OP_FEED, 8'd0, st);
    send_item(OP_FEED, 8'hAA, st);
    do send_item(OP_PULL, 8'h00, st); while (st != ST_END);
    send_item(OP_FEED, 8'h55, st);
  endtask

  task automatic test_random_streams();
    int sizes[11] = '{0, 1, 2, 3, 5, 7, 8, 9, 15, 4, 6};
    int stop_at;
    status_t st;
    stop_at = item_cnt + 900;
    while (item_cnt < stop_at) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_size(4'(sizes[$urandom_range(0, 10)]));
      if ($urandom_range(0, 9) == 0) begin
        repeat (20) send_item(1'($urandom), 8'($urandom), st);
      end else begin
        play_stream(make_codes(clamp_size(size_reg), $urandom_range(10, 80),
                               $urandom_range(10, 60), 2), $urandom_range(25, 70));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    item_cnt = 0;
    no_idle = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    in_valid = 1'b0;
    in_opcode = OP_FEED;
    in_data_byte = 8'd0;
    size_reg = MIN_SIZE_RESET;
    restart_decoder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_special_codes();
    test_wide_roots();
    test_refuse_and_terminator();
    test_random_streams();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/glzw_pkg.sv
sv/glzw_ram.sv
sv/gif_lzw_decoder.sv
tb/sv/tb_gif_lzw_decoder.sv
